### hw/rtl/s256bh_pkg.sv
// Package for the SHA-256 block hasher: word and array types, sequencer states,
// round constants, initial hash values and the SHA-256 bit-mixing functions.
// Depends on nothing; the interfaces and the top level refer to it by scoped names.
package s256bh_pkg;

  typedef logic [31:0] word_t;
  typedef word_t       hash_t [8];
  typedef logic [3:0]  widx_t;
  typedef logic [5:0]  round_t;
  typedef logic [2:0]  hidx_t;

  localparam int unsigned ChunkWords = 16;
  localparam int unsigned HashWords  = 8;
  localparam widx_t       LastWord   = widx_t'(ChunkWords - 1);
  localparam round_t      LastRound  = 6'd63;
  localparam hidx_t       LastHash   = hidx_t'(HashWords - 1);

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_FETCH,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  localparam hash_t IV = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Message schedule mixers
  function automatic word_t ssig0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  // Round mixers
  function automatic word_t bsig0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t choose(input word_t x, input word_t y, input word_t z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic word_t majority(input word_t x, input word_t y, input word_t z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

endpackage

### hw/rtl/s256bh_msg_if.sv
// Message word channel of the SHA-256 block hasher: valid/ready plus payload.
// Depends on s256bh_pkg for the word type.
interface s256bh_msg_if;
  logic                valid;
  logic                ready;
  s256bh_pkg::word_t   msg_word;
  logic                final_chunk;

  modport source (output valid, output msg_word, output final_chunk, input ready);
  modport sink   (input valid, input msg_word, input final_chunk, output ready);
endinterface

### hw/rtl/s256bh_digest_if.sv
// Digest word channel of the SHA-256 block hasher: valid/ready plus payload.
// Depends on s256bh_pkg for the word type.
interface s256bh_digest_if;
  logic                valid;
  logic                ready;
  s256bh_pkg::word_t   digest_word;
  logic                digest_last;

  modport source (output valid, output digest_word, output digest_last, input ready);
  modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

### hw/rtl/sha256_block_hasher.sv
// SHA-256 block hasher top level: word collection, compression sequencer, digest output.
// Depends on s256bh_pkg, s256bh_msg_if and s256bh_digest_if.

// SHA-256 compression over a message that the host has already padded. Feed
// big-endian 32-bit words on the msg channel; every 16 words form one chunk.
// Words are taken one per cycle while the block is collecting a chunk. After
// the 16th word the block stops taking requests and runs the 64 rounds,
// each a fetch state followed by a round state, and then an add state
// folds the result into the chaining value. The round rate is set by the
// message schedule memory, a 16-entry array with one write port and two
// registered read ports: each round needs four schedule words, read as two
// pairs through the two ports. Only the final_chunk bit given with the 16th
// word of a chunk counts. When a final chunk completes, the eight digest
// words go out H0 first, digest_last marking H7, one per accepted request;
// after H7 the chaining value returns to the SHA-256 initial values and the
// block collects the next message. There is no clearing pass after reset;
// the block takes words as soon as reset is released.
module sha256_block_hasher (
  input  logic                    clk,
  input  logic                    rst,
  s256bh_msg_if.sink              msg,
  s256bh_digest_if.source         digest
);

  s256bh_pkg::state_t  state;
  s256bh_pkg::state_t  state_next;

  // Control registers
  s256bh_pkg::widx_t   count;       // words collected in current chunk
  s256bh_pkg::round_t  round;       // current compression round
  logic                final_seen;  // finality of the chunk under compression
  s256bh_pkg::hidx_t   out_idx;     // next digest word to hand out
  s256bh_pkg::hash_t   chain;       // chaining value H0..H7

  // Round datapath registers
  s256bh_pkg::hash_t   wv;          // working variables a..h
  s256bh_pkg::word_t   w16;         // W[t-16] (or W[t] in the first 16 rounds)
  s256bh_pkg::word_t   part;        // W[t-16] + sigma0(W[t-15])
  s256bh_pkg::word_t   hk;          // h + K[t]

  // Schedule memory
  s256bh_pkg::word_t   sched_mem [s256bh_pkg::ChunkWords];
  s256bh_pkg::word_t   q0;
  s256bh_pkg::word_t   q1;
  s256bh_pkg::widx_t   rd_addr0;
  s256bh_pkg::widx_t   rd_addr1;
  logic                wr_en;
  s256bh_pkg::widx_t   wr_addr;
  s256bh_pkg::word_t   wr_data;

  s256bh_pkg::word_t   wt;
  s256bh_pkg::word_t   t1;
  s256bh_pkg::word_t   t2;

  logic                in_accept;
  logic                out_accept;

  assign in_accept  = msg.valid && msg.ready;
  assign out_accept = digest.valid && digest.ready;

  // Round arithmetic. In the first 16 rounds W[t] comes straight from the
  // memory (held in w16); later it is built from the partial sum and the
  // W[t-2], W[t-7] words that arrive this cycle.
  always_comb begin
    if (round[5:4] == 2'b00) begin
      wt = w16;
    end else begin
      wt = part + q1 + s256bh_pkg::ssig1(q0);
    end
    t1 = hk + s256bh_pkg::bsig1(wv[4]) + s256bh_pkg::choose(wv[4], wv[5], wv[6]) + wt;
    t2 = s256bh_pkg::bsig0(wv[0]) + s256bh_pkg::majority(wv[0], wv[1], wv[2]);
  end

  // Sequencer: next state, handshakes and memory port control
  always_comb begin
    state_next = state;
    msg.ready  = 1'b0;
    digest.valid = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = count;
    wr_data    = msg.msg_word;
    rd_addr0   = '0;
    rd_addr1   = 4'd1;
    unique case (state)
      s256bh_pkg::ST_COLLECT: begin
        // Store each word; the first fetch (W[0], W[1]) goes out with the last word.
        msg.ready = 1'b1;
        wr_en     = msg.valid;
        if (msg.valid && count == s256bh_pkg::LastWord) begin
          state_next = s256bh_pkg::ST_FETCH;
        end
      end
      s256bh_pkg::ST_FETCH: begin
        // Ask for W[t-2] and W[t-7] for the round cycle.
        rd_addr0   = round[3:0] + 4'd14;
        rd_addr1   = round[3:0] + 4'd9;
        state_next = s256bh_pkg::ST_ROUND;
      end
      s256bh_pkg::ST_ROUND: begin
        // Write back the expanded word and ask for W[t+1-16], W[t+1-15].
        // None of these addresses meet the write of this cycle or of the
        // round before, so no forwarding is needed.
        wr_en    = (round[5:4] != 2'b00);
        wr_addr  = round[3:0];
        wr_data  = wt;
        rd_addr0 = round[3:0] + 4'd1;
        rd_addr1 = round[3:0] + 4'd2;
        if (round == s256bh_pkg::LastRound) begin
          state_next = s256bh_pkg::ST_ADD;
        end else begin
          state_next = s256bh_pkg::ST_FETCH;
        end
      end
      s256bh_pkg::ST_ADD: begin
        if (final_seen) begin
          state_next = s256bh_pkg::ST_OUT;
        end else begin
          state_next = s256bh_pkg::ST_COLLECT;
        end
      end
      s256bh_pkg::ST_OUT: begin
        digest.valid = 1'b1;
        if (digest.ready && out_idx == s256bh_pkg::LastHash) begin
          state_next = s256bh_pkg::ST_COLLECT;
        end
      end
      default: begin
        state_next = s256bh_pkg::ST_COLLECT;
      end
    endcase
  end

  assign digest.digest_word = chain[out_idx];
  assign digest.digest_last = (out_idx == s256bh_pkg::LastHash);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s256bh_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // Schedule memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sched_mem[wr_addr] <= wr_data;
    end
    q0 <= sched_mem[rd_addr0];
    q1 <= sched_mem[rd_addr1];
  end

  // Control state and chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      round      <= '0;
      final_seen <= 1'b0;
      out_idx    <= '0;
      chain      <= s256bh_pkg::IV;
    end else begin
      if (in_accept) begin
        count <= count + 4'd1;
        if (count == s256bh_pkg::LastWord) begin
          final_seen <= msg.final_chunk;
          round      <= '0;
        end
      end
      if (state == s256bh_pkg::ST_ROUND) begin
        round <= round + 6'd1;
      end
      if (state == s256bh_pkg::ST_ADD) begin
        for (int i = 0; i < s256bh_pkg::HashWords; i++) begin
          chain[i] <= chain[i] + wv[i];
        end
      end
      if (out_accept) begin
        out_idx <= out_idx + 3'd1;
        // Last digest word taken: start the next message from the initial values.
        if (out_idx == s256bh_pkg::LastHash) begin
          chain <= s256bh_pkg::IV;
        end
      end
    end
  end

  // Round datapath
  always_ff @(posedge clk) begin
    if (in_accept && count == s256bh_pkg::LastWord) begin
      // Load a..h from the chaining value as the chunk closes.
      wv <= chain;
    end
    if (state == s256bh_pkg::ST_FETCH) begin
      // q0 = W[t-16] (or W[t]), q1 = W[t-15]
      w16  <= q0;
      part <= q0 + s256bh_pkg::ssig0(q1);
      hk   <= wv[7] + s256bh_pkg::K[round];
    end
    if (state == s256bh_pkg::ST_ROUND) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

endmodule
